[hw/rtl/d2dn_pkg.sv]
// Shared types, constants and the month offset table for the date to day number pipeline.
`timescale 1ns / 1ps

package d2dn_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int DN_W   = 22;
    localparam int DOW_W  = 3;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
    localparam logic [MON_W-1:0]  MON_DEC  = 4'd11;
    localparam logic [MON_W-1:0]  MON_JAN  = 4'd0;
    localparam logic [MON_W-1:0]  MON_FEB  = 4'd1;

    // Month fold: offset the signed month by 12*171 so the quotient is unsigned.
    localparam logic [12:0] MON_BIAS   = 13'd2052;
    localparam logic [8:0]  MON_QBIAS  = 9'd171;
    localparam logic [11:0] RECIP_12   = 12'd2731;   // ceil(2^15 / 12)
    localparam int          RECIP_12_SH = 15;
    localparam logic [12:0] RECIP_100  = 13'd5243;   // ceil(2^19 / 100)
    localparam int          RECIP_100_SH = 19;

    localparam logic [1:0] MODE_360 = 2'd0;
    localparam logic [1:0] MODE_365 = 2'd2;

    localparam logic [DOW_W-1:0] DAYS_PER_WEEK = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [1:0]        mode;
    } fold_t;

    typedef struct packed {
        logic [DN_W-1:0]   day_number;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
    } count_t;

    // Days before the first of each month in a 365-day year.
    function automatic logic [8:0] month_start(input logic [MON_W-1:0] mon);
        logic [8:0] res;
        case (mon)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd59;
            4'd3:    res = 9'd90;
            4'd4:    res = 9'd120;
            4'd5:    res = 9'd151;
            4'd6:    res = 9'd181;
            4'd7:    res = 9'd212;
            4'd8:    res = 9'd243;
            4'd9:    res = 9'd273;
            4'd10:   res = 9'd304;
            4'd11:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/d2dn_fold.sv]
// Two pipeline stages: fold the month into the year, then clamp year, month and day.
`timescale 1ns / 1ps

module d2dn_fold (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            year_in,
    input  logic [11:0]            month_in,
    input  logic [7:0]             day_in,
    input  logic [1:0]             calendar_mode,
    output logic                   out_valid,
    input  logic                   out_ready,
    output d2dn_pkg::fold_t        out_data
);
    import d2dn_pkg::*;

    logic        s1_valid_reg;
    logic [12:0] s1_x_reg;
    logic [8:0]  s1_q_reg;
    logic [15:0] s1_year_reg;
    logic [7:0]  s1_day_reg;
    logic [1:0]  s1_mode_reg;
    logic        s1_ready;

    logic        s2_valid_reg;
    fold_t       s2_data_reg;
    logic        s2_ready;

    logic [12:0] x_next;
    logic [24:0] prod;
    logic [8:0]  q_next;

    logic [12:0] rem_full;
    logic [16:0] year_sum;
    fold_t       fold_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: biased month and quotient by reciprocal multiply
    always_comb
    begin
        x_next = 13'($signed({month_in[11], month_in}) + $signed(MON_BIAS));
        prod   = 25'(x_next) * 25'(RECIP_12);
        q_next = prod[RECIP_12_SH +: 9];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_x_reg    <= x_next;
            s1_q_reg    <= q_next;
            s1_year_reg <= year_in;
            s1_day_reg  <= day_in;
            s1_mode_reg <= calendar_mode;
        end
    end

    // Stage 2: remainder, year carry and clamping
    always_comb
    begin
        rem_full = s1_x_reg - 13'(s1_q_reg) * 13'd12;
        year_sum = 17'($signed(s1_year_reg)) + 17'(s1_q_reg) - 17'(MON_QBIAS);
        fold_next.mode  = s1_mode_reg;
        fold_next.year  = year_sum[YEAR_W-1:0];
        fold_next.month = rem_full[MON_W-1:0];
        if ($signed(year_sum) > $signed(17'(YEAR_MAX)))
        begin
            fold_next.year  = YEAR_MAX;
            fold_next.month = MON_DEC;
        end
        if ($signed(year_sum) < $signed(17'(YEAR_MIN)))
        begin
            fold_next.year  = YEAR_MIN;
            fold_next.month = MON_JAN;
        end
        if (s1_day_reg == 8'd0 || s1_day_reg > 8'd31)
        begin
            fold_next.day = 5'd1;
        end
        else
        begin
            fold_next.day = s1_day_reg[DAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= fold_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

[hw/rtl/d2dn_count.sv]
// Two pipeline stages: per-mode year and month terms with leap days, then the final day sum.
`timescale 1ns / 1ps

module d2dn_count (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  d2dn_pkg::fold_t        in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output d2dn_pkg::count_t       out_data
);
    import d2dn_pkg::*;

    logic              s1_valid_reg;
    logic [DN_W-1:0]   s1_base_reg;
    logic [11:0]       s1_leap_reg;
    logic [DAY_W-1:0]  s1_day_reg;
    logic [YEAR_W-1:0] s1_year_reg;
    logic [MON_W-1:0]  s1_month_reg;
    logic              s1_ready;

    logic              s2_valid_reg;
    count_t            s2_data_reg;
    logic              s2_ready;

    logic [YEAR_W-1:0] leap_year;
    logic [26:0]       cent_prod;
    logic [6:0]        cent;
    logic [11:0]       leap_next;
    logic [DN_W-1:0]   base_next;
    count_t            count_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: January and February count leap days up to the previous year
    always_comb
    begin
        if (in_data.month == MON_JAN || in_data.month == MON_FEB)
        begin
            leap_year = in_data.year - 14'd1;
        end
        else
        begin
            leap_year = in_data.year;
        end
        cent_prod = 27'(leap_year) * 27'(RECIP_100);
        cent      = cent_prod[RECIP_100_SH +: 7];
        leap_next = 12'(leap_year >> 2) - 12'(cent) + 12'(cent >> 2);

        if (in_data.mode == MODE_360)
        begin
            base_next = 22'(in_data.year) * 22'd360 + 22'(in_data.month) * 22'd30;
        end
        else
        begin
            base_next = 22'(in_data.year) * 22'd365 + 22'(month_start(in_data.month));
        end
        if (in_data.mode == MODE_360 || in_data.mode == MODE_365)
        begin
            leap_next = 12'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_base_reg  <= base_next;
            s1_leap_reg  <= leap_next;
            s1_day_reg   <= in_data.day;
            s1_year_reg  <= in_data.year;
            s1_month_reg <= in_data.month;
        end
    end

    // Stage 2: add the pieces
    always_comb
    begin
        count_next.day_number = s1_base_reg + 22'(s1_leap_reg) + 22'(s1_day_reg) - 22'd1;
        count_next.year       = s1_year_reg;
        count_next.month      = s1_month_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= count_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

[hw/rtl/d2dn_week.sv]
// Output stage: day number mod 7 by octal digit sums, weekday column, result register.
`timescale 1ns / 1ps

module d2dn_week (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  d2dn_pkg::count_t       in_data,
    input  logic [2:0]             week_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [47:0]            out_tdata
);
    import d2dn_pkg::*;

    logic              valid_reg;
    logic [47:0]       data_reg;

    logic [23:0]       dn_pad;
    logic [5:0]        digit_sum;
    logic [3:0]        fold_sum;
    logic [DOW_W-1:0]  dow;
    logic [DOW_W-1:0]  ws;
    logic [DOW_W-1:0]  col;
    logic [47:0]       data_next;

    assign in_ready = !valid_reg || out_ready;

    // 8 = 1 mod 7, so summing octal digits keeps the residue
    always_comb
    begin
        dn_pad    = 24'(in_data.day_number);
        digit_sum = 6'd0;
        for (int i = 0; i < 8; i++)
        begin
            digit_sum = digit_sum + 6'(dn_pad[3*i +: 3]);
        end
        fold_sum = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
        if (fold_sum >= 4'd14)
        begin
            dow = 3'(fold_sum - 4'd14);
        end
        else if (fold_sum >= 4'(DAYS_PER_WEEK))
        begin
            dow = 3'(fold_sum - 4'(DAYS_PER_WEEK));
        end
        else
        begin
            dow = fold_sum[DOW_W-1:0];
        end

        // a week start of seven acts as Sunday
        ws = (week_start == DAYS_PER_WEEK) ? 3'd0 : week_start;
        if (dow >= ws)
        begin
            col = dow - ws;
        end
        else
        begin
            col = dow + DAYS_PER_WEEK - ws;
        end

        data_next = {2'b00, in_data.month, in_data.year, col, dow, in_data.day_number};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tdata = data_reg;

endmodule

[hw/rtl/date_to_day_number.sv]
// Top level: date to day number converter with 360, 365 and Gregorian modes.
//
//  port group   dir  payload
//  s_axis       in   tdata: year_in[15:0], month_in[27:16], day_in[35:28]; tuser: calendar_mode
//  m_axis       out  tdata: day_number, day_of_week, weekday_column, normalized_year, month
//  cfg          in   cfg_wdata: week_start, written when cfg_we is high
//
// Accepts one beat per clock while m_axis_tready keeps the pipeline moving; a beat taken
// on s_axis is registered in each stage in turn before it is presented on m_axis.
// The five register stages are: month fold, clamp, mode terms, day sum, week and output.
// Ready is combinational through all stages: a full pipeline with m_axis_tready low drops
// s_axis_tready in the same cycle, and an empty stage still takes a beat, so bubbles
// are squeezed out.
// Reset clears the stage valid bits and sets week_start to Sunday.
`timescale 1ns / 1ps

module date_to_day_number (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // year_in[15:0], month_in[27:16], day_in[35:28], zeros
    input  logic [1:0]  s_axis_tuser,   // calendar_mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // day_number[21:0], day_of_week[24:22],
                                        // weekday_column[27:25], normalized_year[41:28],
                                        // normalized_month[45:42], zeros
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata
);
    import d2dn_pkg::*;

    logic [2:0] week_start_reg;

    logic       fold_valid;
    logic       fold_ready;
    fold_t      fold_data;
    logic       count_valid;
    logic       count_ready;
    count_t     count_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            week_start_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            week_start_reg <= cfg_wdata;
        end
    end

    d2dn_fold u_fold (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .year_in       (s_axis_tdata[15:0]),
        .month_in      (s_axis_tdata[27:16]),
        .day_in        (s_axis_tdata[35:28]),
        .calendar_mode (s_axis_tuser),
        .out_valid     (fold_valid),
        .out_ready     (fold_ready),
        .out_data      (fold_data)
    );

    d2dn_count u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_data   (fold_data),
        .out_valid (count_valid),
        .out_ready (count_ready),
        .out_data  (count_data)
    );

    d2dn_week u_week (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (count_valid),
        .in_ready   (count_ready),
        .in_data    (count_data),
        .week_start (week_start_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tdata  (m_axis_tdata)
    );

endmodule
